// File: hdl/fmhls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmhls_pkg
// Types and fixed constants shared by the four-mic high-pass and selector.
// ----------------------------------------------------------------------------
package fmhls_pkg;

    localparam int NUM_MICS  = 4;
    localparam int MIC_IDX_W = 2;
    localparam int RAW_W     = 32;
    localparam int SAMPLE_W  = 16;

    // serial multiplier geometry
    localparam int MCAND_W = 42;
    localparam int MPLR_W  = 16;
    localparam int DIGIT_W = 4;
    localparam int PROD_W  = MCAND_W + MPLR_W;

    // fixed-point layout
    localparam int STATE_W    = 40;
    localparam int ENERGY_W   = 48;
    localparam int THRESH_W   = 46;
    localparam int GAIN_FRAC  = 4;
    localparam int ALPHA_FRAC = 16;
    localparam int OUT_FRAC   = 8;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = THRESH_W;

    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_MIC_ONE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_MIC_TWO      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_MIC_THREE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_MIC_FOUR     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HPF_COEFFICIENT   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_FRAMES     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SILENCE_THRESHOLD = 3'd6;

    localparam logic [15:0]         GAIN_RESET   = 16'd4096;
    localparam logic [15:0]         ALPHA_RESET  = 16'd63046;
    localparam logic [15:0]         WINDOW_RESET = 16'd48000;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 46'd160000000;

    typedef struct packed {
        logic signed [RAW_W-1:0] mic_one_raw;
        logic signed [RAW_W-1:0] mic_two_raw;
        logic signed [RAW_W-1:0] mic_three_raw;
        logic signed [RAW_W-1:0] mic_four_raw;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] selected_sample;
        logic [MIC_IDX_W-1:0]       selected_mic;
        logic                       window_closed;
    } out_item_t;

endpackage

// File: hdl/four_mic_hpf_loudest_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_mic_hpf_loudest_selector
// Four-mic DC blocker with energy-based selection of the loudest mic.
//
// One frame of four raw samples is taken per transaction. Each mic is shifted,
// gain scaled, high-pass filtered, saturated to 16 bits and squared into its
// window energy; the output carries the selected mic's sample. Every
// window_frames frames the loudest mic above silence_threshold becomes the
// selection for the following frames. All work runs through one radix-16
// digit-serial multiplier: three multiplies for each of the four mics in turn,
// then the finish state loads the result into the output register. Frames are
// taken only in the idle state, so the next one waits until that load. The
// result load waits while the output register still holds a result that has
// not been taken.
// A new frame is accepted as soon as the result is loaded into the output
// register, even if that result has not been taken yet.
// ----------------------------------------------------------------------------
module four_mic_hpf_loudest_selector #(
    parameter int INPUT_SHIFT = 14
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input frames
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  fmhls_pkg::in_item_t                   s_data,
    // results
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output fmhls_pkg::out_item_t                  m_data,
    // configuration writes
    input  logic                                  cfg_we,
    input  logic [fmhls_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fmhls_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int X_W = fmhls_pkg::RAW_W - INPUT_SHIFT;
    localparam int NM  = fmhls_pkg::NUM_MICS;
    localparam int KW  = fmhls_pkg::MIC_IDX_W;
    localparam int SW  = fmhls_pkg::STATE_W;
    localparam int EW  = fmhls_pkg::ENERGY_W;
    localparam int PW  = fmhls_pkg::PROD_W;
    localparam int MW  = fmhls_pkg::MCAND_W;

    localparam logic [KW-1:0] LAST_MIC = KW'(NM - 1);

    localparam logic signed [SW-1:0] STATE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] STATE_MIN = {1'b1, {(SW-1){1'b0}}};

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_G_WAIT = 3'd1;
    localparam logic [2:0] S_A_WAIT = 3'd2;
    localparam logic [2:0] S_Q_WAIT = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    // ---------------- registers ----------------
    logic [2:0]                   state_reg, state_next;
    logic [KW-1:0]                k_reg, k_next;
    fmhls_pkg::in_item_t          frame_reg;

    logic [15:0]                  gain_reg [NM];
    logic [15:0]                  alpha_reg;
    logic [15:0]                  win_reg;
    logic [fmhls_pkg::THRESH_W-1:0] thresh_reg;

    logic signed [SW-1:0]         prev_in_reg  [NM];
    logic signed [SW-1:0]         prev_out_reg [NM];
    logic [EW-1:0]                energy_reg   [NM];

    logic [EW-1:0]                best_reg;
    logic [KW-1:0]                winner_reg;
    logic signed [fmhls_pkg::SAMPLE_W-1:0] sel_sample_reg;
    logic [15:0]                  cnt_reg;
    logic [KW-1:0]                cur_mic_reg;

    fmhls_pkg::out_item_t         out_reg;
    logic                         m_valid_reg;

    // ---------------- multiplier ----------------
    logic                         mul_start;
    logic signed [MW-1:0]         mul_mcand;
    logic [fmhls_pkg::MPLR_W-1:0] mul_mplr;
    logic                         mul_done;
    logic signed [PW-1:0]         p;

    fmhls_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplr    (mul_mplr),
        .done    (mul_done),
        .product (p)
    );

    // ---------------- datapath ----------------
    logic signed [fmhls_pkg::RAW_W-1:0] raw_arr [NM];
    logic signed [fmhls_pkg::RAW_W-1:0] raw_start;
    logic [KW-1:0]                k_start;
    logic signed [X_W-1:0]        x_start;
    logic signed [SW-1:0]         scaled;
    logic signed [MW-1:0]         sum;
    logic signed [SW+1:0]         q;
    logic signed [SW-1:0]         y;
    logic signed [SW-1:0]         y_round;
    logic signed [31:0]           w;
    logic signed [fmhls_pkg::SAMPLE_W-1:0] s16;
    logic signed [fmhls_pkg::SAMPLE_W:0]   s17;
    logic [fmhls_pkg::SAMPLE_W:0]          s_abs;
    logic [EW:0]                  e_sum;
    logic [EW-1:0]                e_new;
    logic [16:0]                  cnt_inc;
    logic [15:0]                  win_eff;
    logic                         closed;
    logic                         accept;
    logic                         fin_fire;
    logic                         out_free;

    always_comb begin
        raw_arr[0] = frame_reg.mic_one_raw;
        raw_arr[1] = frame_reg.mic_two_raw;
        raw_arr[2] = frame_reg.mic_three_raw;
        raw_arr[3] = frame_reg.mic_four_raw;
    end

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign fin_fire = (state_reg == S_FIN) && out_free;

    // operands of the next gain multiply: mic one straight off the port
    assign k_start   = (state_reg == S_IDLE) ? '0 : k_reg + 1'b1;
    assign raw_start = (state_reg == S_IDLE) ? s_data.mic_one_raw : raw_arr[k_start];
    assign x_start   = raw_start[fmhls_pkg::RAW_W-1:INPUT_SHIFT];

    always_comb begin
        scaled = $signed(p[SW+fmhls_pkg::GAIN_FRAC-1:fmhls_pkg::GAIN_FRAC]);
        sum    = MW'(prev_out_reg[k_reg]) + MW'(scaled) - MW'(prev_in_reg[k_reg]);

        q = $signed(p[PW-1:fmhls_pkg::ALPHA_FRAC]);
        if ((q[SW+1] == q[SW]) && (q[SW] == q[SW-1])) begin
            y = q[SW-1:0];
        end else if (q[SW+1]) begin
            y = STATE_MIN;
        end else begin
            y = STATE_MAX;
        end

        // round toward zero before dropping fraction bits
        y_round = y + $signed({{(SW-fmhls_pkg::OUT_FRAC){1'b0}},
                               {fmhls_pkg::OUT_FRAC{y[SW-1]}}});
        w = y_round[SW-1:fmhls_pkg::OUT_FRAC];
        if (w > 32'sd32767) begin
            s16 = 16'sh7FFF;
        end else if (w < -32'sd32768) begin
            s16 = 16'sh8000;
        end else begin
            s16 = w[fmhls_pkg::SAMPLE_W-1:0];
        end
        s17   = (fmhls_pkg::SAMPLE_W+1)'(s16);
        s_abs = s17[fmhls_pkg::SAMPLE_W] ? -s17 : s17;

        e_sum = {1'b0, energy_reg[k_reg]} + (EW+1)'(p[31:0]);
        e_new = e_sum[EW] ? {EW{1'b1}} : e_sum[EW-1:0];

        cnt_inc = {1'b0, cnt_reg} + 17'd1;
        win_eff = (win_reg == '0) ? 16'd1 : win_reg;
        closed  = cnt_inc >= {1'b0, win_eff};
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        mul_start  = 1'b0;
        mul_mcand  = MW'(x_start);
        mul_mplr   = gain_reg[k_start];
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    mul_start  = 1'b1;
                    k_next     = '0;
                    state_next = S_G_WAIT;
                end
            end
            S_G_WAIT: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_mcand  = sum;
                    mul_mplr   = alpha_reg;
                    state_next = S_A_WAIT;
                end
            end
            S_A_WAIT: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_mcand  = MW'(s_abs);
                    mul_mplr   = s_abs[fmhls_pkg::MPLR_W-1:0];
                    state_next = S_Q_WAIT;
                end
            end
            S_Q_WAIT: begin
                if (mul_done) begin
                    if (k_reg == LAST_MIC) begin
                        state_next = S_FIN;
                    end else begin
                        mul_start  = 1'b1;
                        k_next     = k_start;
                        state_next = S_G_WAIT;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            k_reg       <= '0;
            cnt_reg     <= '0;
            cur_mic_reg <= '0;
            m_valid_reg <= 1'b0;
            alpha_reg   <= fmhls_pkg::ALPHA_RESET;
            win_reg     <= fmhls_pkg::WINDOW_RESET;
            thresh_reg  <= fmhls_pkg::THRESH_RESET;
            for (int i = 0; i < NM; i++) begin
                gain_reg[i]     <= fmhls_pkg::GAIN_RESET;
                prev_in_reg[i]  <= '0;
                prev_out_reg[i] <= '0;
                energy_reg[i]   <= '0;
            end
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;

            if (cfg_we) begin
                case (cfg_index)
                    fmhls_pkg::REG_GAIN_MIC_ONE,
                    fmhls_pkg::REG_GAIN_MIC_TWO,
                    fmhls_pkg::REG_GAIN_MIC_THREE,
                    fmhls_pkg::REG_GAIN_MIC_FOUR: begin
                        gain_reg[cfg_index[KW-1:0]] <= cfg_wdata[15:0];
                    end
                    fmhls_pkg::REG_HPF_COEFFICIENT: begin
                        alpha_reg <= cfg_wdata[15:0];
                    end
                    fmhls_pkg::REG_WINDOW_FRAMES: begin
                        win_reg <= cfg_wdata[15:0];
                    end
                    fmhls_pkg::REG_SILENCE_THRESHOLD: begin
                        thresh_reg <= cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end

            if ((state_reg == S_G_WAIT) && mul_done) begin
                prev_in_reg[k_reg] <= scaled;
            end
            if ((state_reg == S_A_WAIT) && mul_done) begin
                prev_out_reg[k_reg] <= y;
            end
            if ((state_reg == S_Q_WAIT) && mul_done) begin
                energy_reg[k_reg] <= e_new;
            end

            if (fin_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (fin_fire) begin
                if (closed) begin
                    cnt_reg <= '0;
                    if (best_reg > EW'(thresh_reg)) begin
                        cur_mic_reg <= winner_reg;
                    end
                    for (int i = 0; i < NM; i++) begin
                        energy_reg[i] <= '0;
                    end
                end else begin
                    cnt_reg <= cnt_inc[15:0];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            frame_reg  <= s_data;
            best_reg   <= '0;
            winner_reg <= cur_mic_reg;
        end
        if ((state_reg == S_A_WAIT) && mul_done && (k_reg == cur_mic_reg)) begin
            sel_sample_reg <= s16;
        end
        // strict compare keeps the earliest mic on a tie
        if ((state_reg == S_Q_WAIT) && mul_done && (e_new > best_reg)) begin
            best_reg   <= e_new;
            winner_reg <= k_reg;
        end
        if (fin_fire) begin
            out_reg.selected_sample <= sel_sample_reg;
            out_reg.selected_mic    <= cur_mic_reg;
            out_reg.window_closed   <= closed;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // ---------------- assertions ----------------
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> ((state_reg == S_G_WAIT) || (state_reg == S_A_WAIT) ||
                      (state_reg == S_Q_WAIT)))
        else $error("multiplier finished outside a wait state");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input taken again while a frame is in work");

    a_mic_switch_on_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_mic_reg != $past(cur_mic_reg)) |-> $past(fin_fire && closed))
        else $error("selection changed outside a window decision");

    a_energy_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (fin_fire && closed) |=> (energy_reg[0] == '0))
        else $error("energy not cleared after window decision");

endmodule

// File: hdl/fmhls_serial_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmhls_serial_mul
// Digit-serial signed-by-unsigned multiplier. The multiplier operand is
// consumed one digit per cycle from a shift register; the multiplicand shifts
// left by one digit per cycle. Product is valid while done is high and holds
// until the next start.
// ----------------------------------------------------------------------------
module fmhls_serial_mul (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [fmhls_pkg::MCAND_W-1:0] mcand,
    input  logic [fmhls_pkg::MPLR_W-1:0]        mplr,
    output logic                                done,
    output logic signed [fmhls_pkg::PROD_W-1:0] product
);

    localparam int STEPS = fmhls_pkg::MPLR_W / fmhls_pkg::DIGIT_W;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

    logic signed [fmhls_pkg::PROD_W-1:0]           acc_reg;
    logic signed [fmhls_pkg::PROD_W-1:0]           mcand_sh_reg;
    logic [fmhls_pkg::MPLR_W-1:0]                  mplr_sh_reg;
    logic [CNT_W-1:0]                              cnt_reg;
    logic                                          busy_reg;
    logic                                          done_reg;
    logic signed [fmhls_pkg::PROD_W+fmhls_pkg::DIGIT_W:0] partial;

    always_comb begin
        partial = mcand_sh_reg * $signed({1'b0, mplr_sh_reg[fmhls_pkg::DIGIT_W-1:0]});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == LAST_STEP);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg      <= '0;
            mcand_sh_reg <= fmhls_pkg::PROD_W'(mcand);
            mplr_sh_reg  <= mplr;
        end else if (busy_reg) begin
            acc_reg      <= acc_reg + partial[fmhls_pkg::PROD_W-1:0];
            mcand_sh_reg <= mcand_sh_reg <<< fmhls_pkg::DIGIT_W;
            mplr_sh_reg  <= mplr_sh_reg >> fmhls_pkg::DIGIT_W;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule
